[rtl/interrupt_level_owner_tracker_defines.svh]
// assertion macros for the interrupt level owner tracker
`ifndef INTERRUPT_LEVEL_OWNER_TRACKER_DEFINES_SVH
`define INTERRUPT_LEVEL_OWNER_TRACKER_DEFINES_SVH

// same-cycle implication, checked on clk_i outside reset
`define ILOT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// implication that looks ahead a fixed number of cycles given in cons
`define ILOT_ASSERT_SEQ(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> cons) \
    else $error(msg);

`endif

[rtl/ilot_pkg.sv]
// types and constants shared by the interrupt level owner tracker
package ilot_pkg;

  localparam int MAX_LEVEL      = 7;
  localparam int THREAD_ID_BITS = 32;

  typedef enum logic [2:0] {
    CMD_GET          = 3'd0,
    CMD_GET_IF_OWNER = 3'd1,
    CMD_SET          = 3'd2,
    CMD_SET_AS       = 3'd3,
    CMD_ENTER        = 3'd4,
    CMD_EXIT         = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_OWNER = 2'd1,
    ST_BUSY      = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_SUSPEND = 2'd1,
    ACT_RESUME  = 2'd2,
    ACT_YIELD   = 2'd3
  } action_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [2:0]  level;
    logic [31:0] thread_id;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic [2:0]  old_level;
    action_e     action;
    logic [31:0] action_thread;
  } res_t;

  // owner table update for one command
  typedef struct packed {
    logic wr_en;
    logic clr_cur;
    logic clr_floor;
  } owner_ctl_t;

endpackage

[rtl/ilot_in_reg.sv]
// input register for one command beat
module ilot_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  ilot_pkg::item_t item_i,
  output logic           valid_o,
  output ilot_pkg::item_t item_o
);

  logic            valid_q;
  ilot_pkg::item_t item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

[rtl/ilot_owner_tbl.sv]
// per-level owner thread table
module ilot_owner_tbl #(
  parameter int MAX_LEVEL      = ilot_pkg::MAX_LEVEL,
  parameter int THREAD_ID_BITS = ilot_pkg::THREAD_ID_BITS,
  localparam int Depth         = MAX_LEVEL + 1,
  localparam int LvlW          = $clog2(Depth)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  ilot_pkg::owner_ctl_t      ctl_i,
  input  logic [LvlW-1:0]           wr_addr_i,
  input  logic [THREAD_ID_BITS-1:0] wr_data_i,
  input  logic [LvlW-1:0]           cur_i,
  input  logic [LvlW-1:0]           floor_i,
  input  logic                      cfg_we_i,
  input  logic [THREAD_ID_BITS-1:0] cfg_data_i,
  input  logic [LvlW-1:0]           rd_addr_i,
  output logic [THREAD_ID_BITS-1:0] rd_data_o
);

  logic [THREAD_ID_BITS-1:0] owner_q [Depth];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        owner_q[i] <= '0;
      end
    end else begin
      if (ctl_i.clr_cur) begin
        owner_q[cur_i] <= '0;
      end
      if (ctl_i.clr_floor) begin
        owner_q[floor_i] <= '0;
      end
      if (ctl_i.wr_en) begin
        owner_q[wr_addr_i] <= wr_data_i;
      end
      // base thread write lands in the lowest level
      if (cfg_we_i) begin
        owner_q[0] <= cfg_data_i;
      end
    end
  end

  assign rd_data_o = owner_q[rd_addr_i];

endmodule

[rtl/ilot_exec.sv]
// command execution: level state, current owner and result forming
module ilot_exec #(
  parameter int MAX_LEVEL      = ilot_pkg::MAX_LEVEL,
  parameter int THREAD_ID_BITS = ilot_pkg::THREAD_ID_BITS,
  localparam int LvlW          = $clog2(MAX_LEVEL + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  ilot_pkg::item_t           item_i,
  input  logic                      cfg_we_i,
  input  logic [THREAD_ID_BITS-1:0] cfg_owner_i,
  input  logic [THREAD_ID_BITS-1:0] rd_data_i,
  output logic [LvlW-1:0]           rd_addr_o,
  output logic [LvlW-1:0]           lvl_o,
  output logic [LvlW-1:0]           cur_o,
  output logic [LvlW-1:0]           floor_o,
  output logic [THREAD_ID_BITS-1:0] wr_data_o,
  output ilot_pkg::owner_ctl_t      ctl_o,
  output ilot_pkg::res_t            res_o
);

  logic [LvlW-1:0]           cur_q, cur_d;
  logic [LvlW-1:0]           floor_q, floor_d;
  // mirror of the owner at the current level
  logic [THREAD_ID_BITS-1:0] own_q, own_d;

  logic [LvlW-1:0]           lvl;
  logic [THREAD_ID_BITS-1:0] caller;
  logic [THREAD_ID_BITS-1:0] exit_own;
  logic                      is_owner;

  always_comb begin
    if (32'(item_i.level) > MAX_LEVEL) begin
      lvl = LvlW'(MAX_LEVEL);
    end else begin
      lvl = LvlW'(item_i.level);
    end
  end

  assign caller   = THREAD_ID_BITS'(item_i.thread_id);
  assign is_owner = (caller == own_q);

  // lowering below the floor lands on the floor
  assign rd_addr_o = (item_i.cmd != ilot_pkg::CMD_EXIT && lvl < floor_q) ? floor_q : lvl;

  // exit clears the old current and floor entries before reading the target
  assign exit_own = (lvl == cur_q || lvl == floor_q) ? '0 : rd_data_i;

  always_comb begin
    cur_d                = cur_q;
    floor_d              = floor_q;
    own_d                = own_q;
    ctl_o                = '0;
    wr_data_o            = caller;
    res_o.status         = ilot_pkg::ST_OK;
    res_o.old_level      = 3'(cur_q);
    res_o.action         = ilot_pkg::ACT_NONE;
    res_o.action_thread  = '0;
    if (valid_i) begin
      case (item_i.cmd)
        ilot_pkg::CMD_GET_IF_OWNER: begin
          if (!is_owner) begin
            res_o.status    = ilot_pkg::ST_NOT_OWNER;
            res_o.old_level = '0;
          end
        end
        ilot_pkg::CMD_SET, ilot_pkg::CMD_SET_AS: begin
          if (item_i.cmd == ilot_pkg::CMD_SET_AS && !is_owner) begin
            res_o.status    = ilot_pkg::ST_NOT_OWNER;
            res_o.old_level = '0;
          end else if (cur_q < lvl) begin
            ctl_o.wr_en = 1'b1;
            wr_data_o   = (item_i.cmd == ilot_pkg::CMD_SET_AS) ? caller : own_q;
            cur_d       = lvl;
            own_d       = wr_data_o;
          end else if (cur_q > lvl) begin
            ctl_o.clr_cur = (cur_q > floor_q);
            cur_d         = rd_addr_o;
            own_d         = rd_data_i;
          end
        end
        ilot_pkg::CMD_ENTER: begin
          if (lvl <= cur_q) begin
            res_o.status        = ilot_pkg::ST_BUSY;
            res_o.old_level     = '0;
            res_o.action        = ilot_pkg::ACT_YIELD;
            res_o.action_thread = 32'(own_q);
          end else begin
            if (own_q != '0) begin
              res_o.action        = ilot_pkg::ACT_SUSPEND;
              res_o.action_thread = 32'(own_q);
            end
            ctl_o.wr_en = 1'b1;
            cur_d       = lvl;
            floor_d     = lvl;
            own_d       = caller;
          end
        end
        ilot_pkg::CMD_EXIT: begin
          ctl_o.clr_cur   = 1'b1;
          ctl_o.clr_floor = 1'b1;
          if (exit_own != '0) begin
            res_o.action        = ilot_pkg::ACT_RESUME;
            res_o.action_thread = 32'(exit_own);
          end
          cur_d   = lvl;
          floor_d = lvl;
          own_d   = exit_own;
        end
        default: begin
        end
      endcase
    end
    if (cfg_we_i && cur_d == '0) begin
      own_d = cfg_owner_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= '0;
      floor_q <= '0;
      own_q   <= '0;
    end else begin
      cur_q   <= cur_d;
      floor_q <= floor_d;
      own_q   <= own_d;
    end
  end

  assign lvl_o   = lvl;
  assign cur_o   = cur_q;
  assign floor_o = floor_q;

endmodule

[rtl/interrupt_level_owner_tracker.sv]
// top level of the interrupt level owner tracker
// a command is captured in the input register, and its result is then captured in the result register
// throughput: one command per cycle, busy stays low, one result per command
// each command resolves in combinational compares and muxing on the owner table
// reset clears current and floor levels and all owners; base thread reads as zero
// results are strobed for one cycle and cannot be stalled by the receiver
`include "interrupt_level_owner_tracker_defines.svh"

module interrupt_level_owner_tracker #(
  parameter int MAX_LEVEL      = ilot_pkg::MAX_LEVEL,
  parameter int THREAD_ID_BITS = ilot_pkg::THREAD_ID_BITS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  ilot_pkg::item_t cmd_i,
  output logic            done_o,
  output ilot_pkg::res_t  res_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [31:0]     cfg_data_i
);

  localparam int LvlW = $clog2(MAX_LEVEL + 1);

  logic                      in_valid;
  ilot_pkg::item_t           in_item;
  logic                      cfg_we;
  logic [THREAD_ID_BITS-1:0] cfg_owner;
  logic [LvlW-1:0]           rd_addr;
  logic [THREAD_ID_BITS-1:0] rd_data;
  logic [LvlW-1:0]           lvl;
  logic [LvlW-1:0]           cur;
  logic [LvlW-1:0]           floor_lvl;
  logic [THREAD_ID_BITS-1:0] wr_data;
  ilot_pkg::owner_ctl_t      ctl;
  ilot_pkg::res_t            res;
  logic                      done_q;
  ilot_pkg::res_t            res_q;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign cfg_owner   = THREAD_ID_BITS'(cfg_data_i);

  ilot_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (start && !busy),
    .item_i  (cmd_i),
    .valid_o (in_valid),
    .item_o  (in_item)
  );

  ilot_exec #(
    .MAX_LEVEL      (MAX_LEVEL),
    .THREAD_ID_BITS (THREAD_ID_BITS)
  ) u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid),
    .item_i      (in_item),
    .cfg_we_i    (cfg_we),
    .cfg_owner_i (cfg_owner),
    .rd_data_i   (rd_data),
    .rd_addr_o   (rd_addr),
    .lvl_o       (lvl),
    .cur_o       (cur),
    .floor_o     (floor_lvl),
    .wr_data_o   (wr_data),
    .ctl_o       (ctl),
    .res_o       (res)
  );

  ilot_owner_tbl #(
    .MAX_LEVEL      (MAX_LEVEL),
    .THREAD_ID_BITS (THREAD_ID_BITS)
  ) u_owner_tbl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .wr_addr_i  (lvl),
    .wr_data_i  (wr_data),
    .cur_i      (cur),
    .floor_i    (floor_lvl),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_owner),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid) begin
      res_q <= res;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  `ILOT_ASSERT_SEQ(a_result_follows, start && !busy, (##2 done_o), "command beat lost")
  `ILOT_ASSERT_NOW(a_fail_no_level, done_o && res_o.status != ilot_pkg::ST_OK,
                   res_o.old_level == 3'd0, "failed command reports a level")
  `ILOT_ASSERT_NOW(a_none_no_thread, done_o && res_o.action == ilot_pkg::ACT_NONE,
                   res_o.action_thread == 32'd0, "no action but thread named")

endmodule
